// ===== design/rprs_pkg.sv =====
`default_nettype none

package rprs_pkg;

    localparam int TIME_BITS  = 48;
    localparam int GAP_W      = 20;
    localparam int STEP_W     = 9;
    localparam int HOLD_MS_W  = 13;
    localparam int HOLD_US_W  = 23;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    localparam logic [GAP_W-1:0]     MIN_GAP_US        = GAP_W'(5000);
    localparam logic [HOLD_US_W-1:0] US_PER_MS         = HOLD_US_W'(1000);
    localparam logic [STEP_W-1:0]    RST_GAP_STEP_US   = STEP_W'(30);
    localparam logic [GAP_W-1:0]     RST_INITIAL_GAP   = GAP_W'(200000);
    localparam logic [HOLD_US_W-1:0] RST_HOLD_LIMIT_US = HOLD_US_W'(1000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_STEP    = 2'd0,
        CFG_INITIAL_GAP = 2'd1,
        CFG_FINAL_HOLD  = 2'd2,
        CFG_RESTART     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [TIME_BITS-1:0] now_us;
        logic                 reset_request;
    } t_in_beat;

    typedef struct packed {
        logic             fire_pulse;
        logic             hold_on;
        logic [GAP_W-1:0] gap_now_us;
    } t_out_beat;

    typedef struct packed {
        logic [STEP_W-1:0]    gap_step_us;
        logic [GAP_W-1:0]     initial_gap_us;
        logic [HOLD_US_W-1:0] hold_limit_us;
        logic                 restart_after_climb;
    } t_cfg;

endpackage

`default_nettype wire

// ===== design/rprs_cfg.sv =====
`default_nettype none

module rprs_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rprs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rprs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rprs_pkg::t_cfg                      o_cfg
);
    import rprs_pkg::*;

    t_cfg r_cfg;
    logic [HOLD_US_W-1:0] hold_us;

    // ms to us once, at write time
    assign hold_us = HOLD_US_W'(i_cfg_data[HOLD_MS_W-1:0]) * US_PER_MS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gap_step_us         <= RST_GAP_STEP_US;
            r_cfg.initial_gap_us      <= RST_INITIAL_GAP;
            r_cfg.hold_limit_us       <= RST_HOLD_LIMIT_US;
            r_cfg.restart_after_climb <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAP_STEP:    r_cfg.gap_step_us         <= i_cfg_data[STEP_W-1:0];
                CFG_INITIAL_GAP: r_cfg.initial_gap_us      <= i_cfg_data[GAP_W-1:0];
                CFG_FINAL_HOLD:  r_cfg.hold_limit_us       <= hold_us;
                CFG_RESTART:     r_cfg.restart_after_climb <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/rprs_step.sv =====
`default_nettype none

module rprs_step (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rprs_pkg::t_cfg       i_cfg,
    input  wire logic                 i_en,
    input  wire rprs_pkg::t_in_beat   i_beat,
    output rprs_pkg::t_out_beat       o_beat
);
    import rprs_pkg::*;

    logic [GAP_W-1:0]     r_gap,        n_gap;
    logic [TIME_BITS-1:0] r_next_fire,  n_next_fire;
    logic [TIME_BITS-1:0] r_hold_start, n_hold_start;
    logic                 r_in_final,   n_in_final;
    logic                 r_hold_level, n_hold_level;

    logic [GAP_W-1:0]     gap_b;
    logic [TIME_BITS-1:0] hold_start_b;
    logic                 in_final_b;
    logic                 hold_level_b;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] held_for;
    logic [TIME_BITS:0]   sched;
    logic [GAP_W-1:0]     step_ext;
    logic                 expire;
    logic                 fire;

    always_comb begin
        now      = i_beat.now_us;
        step_ext = GAP_W'(i_cfg.gap_step_us);

        // requested reset applies before the tick
        if (i_beat.reset_request) begin
            gap_b        = i_cfg.initial_gap_us;
            hold_start_b = '0;
            in_final_b   = 1'b0;
            hold_level_b = 1'b0;
        end else begin
            gap_b        = r_gap;
            hold_start_b = r_hold_start;
            in_final_b   = r_in_final;
            hold_level_b = r_hold_level;
        end

        held_for = now - hold_start_b;
        expire   = in_final_b && i_cfg.restart_after_climb && (now > hold_start_b)
                   && (held_for > TIME_BITS'(i_cfg.hold_limit_us));

        n_gap        = gap_b;
        n_hold_start = hold_start_b;
        n_in_final   = in_final_b;
        n_hold_level = hold_level_b;
        n_next_fire  = r_next_fire;
        fire         = 1'b0;
        sched        = '0;

        if (expire) begin
            n_gap        = i_cfg.initial_gap_us;
            n_hold_start = '0;
            n_in_final   = 1'b0;
            n_hold_level = 1'b0;
        end else if (now > r_next_fire) begin
            fire = 1'b1;
            if (!in_final_b) begin
                if (gap_b < MIN_GAP_US + step_ext) begin
                    n_gap        = MIN_GAP_US;
                    n_in_final   = 1'b1;
                    n_hold_start = now;
                    n_hold_level = 1'b1;
                end else begin
                    n_gap = gap_b - step_ext;
                end
            end
            // saturate the schedule at the top of the time range
            sched       = {1'b0, now} + (TIME_BITS + 1)'(n_gap);
            n_next_fire = sched[TIME_BITS] ? '1 : sched[TIME_BITS-1:0];
        end

        o_beat.fire_pulse = fire;
        o_beat.hold_on    = n_hold_level;
        o_beat.gap_now_us = n_gap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap        <= RST_INITIAL_GAP;
            r_next_fire  <= '0;
            r_hold_start <= '0;
            r_in_final   <= 1'b0;
            r_hold_level <= 1'b0;
        end else if (i_en) begin
            r_gap        <= n_gap;
            r_next_fire  <= n_next_fire;
            r_hold_start <= n_hold_start;
            r_in_final   <= n_in_final;
            r_hold_level <= n_hold_level;
        end
    end

endmodule

`default_nettype wire

// ===== design/ramping_pulse_rate_sequencer_top.sv =====
// Ramping pulse-rate sequencer.
// Input channel (i_in_valid / o_in_ready / i_in) carries one timestamp tick per beat:
// now_us and reset_request. Output channel (o_out_valid / i_out_ready / o_out)
// returns one beat per tick: fire_pulse, hold_on and the gap after the tick.
// Configuration is a write-only port (i_cfg_we, i_cfg_idx, i_cfg_data): index 0 gap
// step, 1 initial gap, 2 final hold in ms, 3 restart after climb. Write only while idle.
// A tick accepted into the input register passes through the step logic into the
// output register. Throughput: one tick per cycle while the receiver does not stall.
// The per-tick compare, subtract, clamp and schedule add sit in combinational logic
// between the two registers; the sequencer state updates as the output register loads.
// Reset (i_rst_n low, synchronous) drops both pipeline registers, returns the
// configuration to its defaults and restarts the climb with the next pulse due at zero.
// When the receiver stalls, the result holds in the output register; one more tick
// is taken into the input register, after which o_in_ready drops until the
// output beat is taken.
`default_nettype none

module ramping_pulse_rate_sequencer_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire rprs_pkg::t_in_beat              i_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output rprs_pkg::t_out_beat                  o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [rprs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rprs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rprs_pkg::*;

    t_cfg      cfg;
    t_in_beat  r_in;
    logic      r_in_vld;
    t_out_beat r_out;
    logic      r_out_vld;
    t_out_beat step_out;
    logic      advance;
    logic      step_en;

    assign advance    = !r_out_vld || i_out_ready;
    assign step_en    = r_in_vld && advance;
    assign o_in_ready = !r_in_vld || advance;

    rprs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rprs_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_en    (step_en),
        .i_beat  (r_in),
        .o_beat  (step_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_out <= step_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== design/rprs_checker.sv =====
`default_nettype none

module rprs_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_in_ready,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_ready,
    input wire rprs_pkg::t_out_beat              o_out
);
    import rprs_pkg::*;

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat valid right after reset");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("output beat changed while stalled");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled with room downstream");

    a_hold_means_min_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.hold_on |-> o_out.gap_now_us == MIN_GAP_US)
        else $error("hold on without clamped gap");

endmodule

bind ramping_pulse_rate_sequencer_top rprs_checker u_rprs_checker (.*);

`default_nettype wire
